// ===== src/mle_pkg.sv =====
// Shared types, codes and sizes for the misaligned load/store emulator.
package mle_pkg;

	localparam int REG_COUNT = 32;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ACT_SAVE = 2'd0;
	localparam logic [1:0] ACT_TRAP = 2'd1;
	localparam logic [1:0] ACT_BYTE = 2'd2;

	localparam logic [31:0] CAUSE_LOAD = 32'd4;
	localparam logic [31:0] CAUSE_STORE = 32'd6;

	localparam logic [2:0] F3_LH = 3'd1;
	localparam logic [2:0] F3_LW = 3'd2;
	localparam logic [2:0] F3_LHU = 3'd5;
	localparam logic [2:0] F3_SH = 3'd1;
	localparam logic [2:0] F3_SW = 3'd2;
	localparam logic [2:0] F3_C_LW = 3'd2;
	localparam logic [2:0] F3_C_SW = 3'd6;

	localparam logic [2:0] SIZE_HALF = 3'd2;
	localparam logic [2:0] SIZE_WORD = 3'd4;

	typedef enum logic [1:0] {
		KIND_READ = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_DONE = 2'd2,
		KIND_FATAL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_STORE = 2'd1,
		OP_DONE = 2'd2,
		OP_FATAL = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] addr;
		logic [2:0]  size;
		logic [31:0] data;
		logic [4:0]  dest;
		logic [31:0] pc;
		logic [31:0] cause;
	} cmd_t;

endpackage

// ===== src/mle_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/mle_front.sv =====
// Front end: accepts transactions, keeps the saved registers and load state, decodes traps.
module mle_front import mle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [4:0]  reg_index,
	input  logic [31:0] reg_value,
	input  logic [31:0] trap_cause,
	input  logic [31:0] fault_pc,
	input  logic [31:0] instruction,
	input  logic [7:0]  read_byte,
	output logic        push,
	input  logic        q_full,
	output cmd_t        push_cmd
);

	typedef enum logic [3:0] {
		FS_IDLE = 4'b0001,
		FS_BASE = 4'b0010,
		FS_DATA = 4'b0100,
		FS_PUSH = 4'b1000
	} fstate_t;

	fstate_t     state_q;
	cmd_t        cmd_q;
	logic [31:0] cause_q;
	logic [31:0] pc_q;
	logic [31:0] insn_q;
	logic        lif_q;
	logic [4:0]  dest_q;
	logic [2:0]  size_q;
	logic [2:0]  br_q;
	logic [31:0] asm_q;
	logic        sx_q;
	logic [31:0] npc_q;

	logic                 accept;
	logic                 ram_we;
	logic [REG_IDX_W-1:0] ram_waddr;
	logic [31:0]          ram_wdata;
	logic [REG_IDX_W-1:0] ram_raddr;
	logic [31:0]          ram_rdata;

	logic        byte_take;
	logic [31:0] asm_next;
	logic [2:0]  br_next;
	logic        load_done;
	logic [31:0] load_value;

	logic        is_full;
	logic [2:0]  f3_full;
	logic [2:0]  f3_comp;
	logic [31:0] base;
	logic [31:0] store_data;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] c_off;
	logic [31:0] next_pc;
	cmd_t        dec_cmd;
	logic        dec_load;
	logic        dec_store;
	logic        dec_sx;
	logic [4:0]  dec_dest;

	function automatic logic [4:0] base_index(input logic [31:0] insn);
		if (insn[1:0] == 2'b11) begin
			return insn[19:15];
		end
		return {2'b01, insn[9:7]};
	endfunction

	function automatic logic [4:0] data_index(input logic [31:0] insn);
		if (insn[1:0] == 2'b11) begin
			return insn[24:20];
		end
		return {2'b01, insn[4:2]};
	endfunction

	mle_ram #(
		.WIDTH(32),
		.DEPTH(REG_COUNT)
	) u_regs (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_stall = (state_q != FS_IDLE);
	assign accept = in_valid && !in_stall;
	assign push = (state_q == FS_PUSH) && !q_full;
	assign push_cmd = cmd_q;

	assign byte_take = accept && (action == ACT_BYTE) && lif_q;
	assign asm_next = asm_q | ({24'd0, read_byte} << {br_q[1:0], 3'b000});
	assign br_next = br_q + 3'd1;
	assign load_done = byte_take && (br_next >= size_q);
	assign load_value = sx_q ? {{16{asm_next[15]}}, asm_next[15:0]} : asm_next;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = reg_index;
		ram_wdata = reg_value;
		if (accept && (action == ACT_SAVE) && (reg_index != 5'd0)) begin
			ram_we = 1'b1;
		end else if (load_done && (dest_q != 5'd0)) begin
			ram_we = 1'b1;
			ram_waddr = dest_q;
			ram_wdata = load_value;
		end
	end

	assign ram_raddr = (state_q == FS_IDLE) ? base_index(instruction) : data_index(insn_q);

	assign is_full = (insn_q[1:0] == 2'b11);
	assign f3_full = insn_q[14:12];
	assign f3_comp = insn_q[15:13];
	assign base = (base_index(insn_q) == 5'd0) ? 32'd0 : ram_rdata;
	assign store_data = (data_index(insn_q) == 5'd0) ? 32'd0 : ram_rdata;
	assign imm_i = {{20{insn_q[31]}}, insn_q[31:20]};
	assign imm_s = {{20{insn_q[31]}}, insn_q[31:25], insn_q[11:7]};
	assign c_off = {25'd0, insn_q[5], insn_q[12:10], insn_q[6], 2'b00};
	assign next_pc = pc_q + (is_full ? 32'd4 : 32'd2);

	always_comb begin
		dec_cmd = '0;
		dec_cmd.op = OP_FATAL;
		dec_cmd.pc = pc_q;
		dec_cmd.cause = cause_q;
		dec_load = 1'b0;
		dec_store = 1'b0;
		dec_sx = 1'b0;
		dec_dest = is_full ? insn_q[11:7] : {2'b01, insn_q[4:2]};
		if (is_full) begin
			if (cause_q == CAUSE_LOAD) begin
				dec_cmd.addr = base + imm_i;
				priority if (f3_full == F3_LH) begin
					dec_load = 1'b1;
					dec_sx = 1'b1;
					dec_cmd.size = SIZE_HALF;
				end else if (f3_full == F3_LHU) begin
					dec_load = 1'b1;
					dec_cmd.size = SIZE_HALF;
				end else if (f3_full == F3_LW) begin
					dec_load = 1'b1;
					dec_cmd.size = SIZE_WORD;
				end else begin
					dec_load = 1'b0;
				end
			end else begin
				dec_cmd.addr = base + imm_s;
				priority if (f3_full == F3_SH) begin
					dec_store = 1'b1;
					dec_cmd.size = SIZE_HALF;
				end else if (f3_full == F3_SW) begin
					dec_store = 1'b1;
					dec_cmd.size = SIZE_WORD;
				end else begin
					dec_store = 1'b0;
				end
			end
		end else begin
			dec_cmd.addr = base + c_off;
			dec_cmd.size = SIZE_WORD;
			if ((insn_q[1:0] == 2'b00) && (f3_comp == F3_C_LW)) begin
				dec_load = 1'b1;
			end else if ((insn_q[1:0] == 2'b00) && (f3_comp == F3_C_SW)) begin
				dec_store = 1'b1;
			end
		end
		if (dec_load) begin
			dec_cmd.op = OP_LOAD;
		end else if (dec_store) begin
			dec_cmd.op = OP_STORE;
			dec_cmd.pc = next_pc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			lif_q <= 1'b0;
			dest_q <= '0;
			size_q <= '0;
			br_q <= '0;
			asm_q <= '0;
			sx_q <= 1'b0;
			npc_q <= '0;
		end else begin
			unique case (state_q)
				FS_IDLE: begin
					if (accept && (action == ACT_TRAP)) begin
						if ((trap_cause == CAUSE_LOAD) || (trap_cause == CAUSE_STORE)) begin
							lif_q <= 1'b0;
							state_q <= FS_BASE;
						end else begin
							state_q <= FS_PUSH;
						end
					end else if (byte_take) begin
						asm_q <= asm_next;
						br_q <= br_next;
						if (load_done) begin
							lif_q <= 1'b0;
							state_q <= FS_PUSH;
						end
					end
				end
				FS_BASE: begin
					if (dec_load) begin
						lif_q <= 1'b1;
						dest_q <= dec_dest;
						size_q <= dec_cmd.size;
						sx_q <= dec_sx;
						npc_q <= next_pc;
						br_q <= '0;
						asm_q <= '0;
					end
					state_q <= dec_store ? FS_DATA : FS_PUSH;
				end
				FS_DATA: begin
					state_q <= FS_PUSH;
				end
				FS_PUSH: begin
					if (!q_full) begin
						state_q <= FS_IDLE;
					end
				end
				default: begin
					state_q <= FS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FS_IDLE: begin
				if (accept && (action == ACT_TRAP)) begin
					cause_q <= trap_cause;
					pc_q <= fault_pc;
					insn_q <= instruction;
					cmd_q <= '{op: OP_FATAL, addr: 32'd0, size: 3'd0, data: 32'd0,
						dest: 5'd0, pc: fault_pc, cause: trap_cause};
				end else if (load_done) begin
					cmd_q <= '{op: OP_DONE, addr: 32'd0, size: 3'd0,
						data: (dest_q == 5'd0) ? 32'd0 : load_value, dest: dest_q,
						pc: npc_q, cause: 32'd0};
				end
			end
			FS_BASE: begin
				cmd_q <= dec_cmd;
			end
			FS_DATA: begin
				cmd_q.data <= store_data;
			end
			FS_PUSH: begin
				cmd_q <= cmd_q;
			end
			default: begin
				cmd_q <= cmd_q;
			end
		endcase
	end

endmodule

// ===== src/mle_queue.sv =====
// Small command queue between the front end and the result sequencer.
module mle_queue import mle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic full,
	output logic empty
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
		if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + QPTR_W'(1);
	endfunction

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== src/mle_back.sv =====
// Back end: expands queued commands into one result transaction per cycle while out_stall is low.
module mle_back import mle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] bus_address,
	output logic [7:0]  write_byte,
	output logic [4:0]  dest_reg,
	output logic [31:0] dest_value,
	output logic [31:0] resume_pc,
	output logic [31:0] fatal_cause,
	output logic        last
);

	logic       busy_q;
	cmd_t       cur_q;
	logic [2:0] idx_q;

	kind_t       kind_c;
	logic [31:0] step_addr;
	logic        out_fire;

	assign out_valid = busy_q;
	assign out_fire = out_valid && !out_stall;
	assign pop = !q_empty && (!busy_q || (out_fire && last));
	assign step_addr = cur_q.addr + {29'd0, idx_q};
	assign kind = kind_c;

	always_comb begin
		kind_c = KIND_FATAL;
		bus_address = '0;
		write_byte = '0;
		dest_reg = '0;
		dest_value = '0;
		resume_pc = '0;
		fatal_cause = '0;
		last = 1'b1;
		unique case (cur_q.op)
			OP_LOAD: begin
				kind_c = KIND_READ;
				bus_address = step_addr;
				last = (idx_q == cur_q.size - 3'd1);
			end
			OP_STORE: begin
				if (idx_q == cur_q.size) begin
					kind_c = KIND_DONE;
					resume_pc = cur_q.pc;
				end else begin
					kind_c = KIND_WRITE;
					bus_address = step_addr;
					write_byte = cur_q.data[{idx_q[1:0], 3'b000} +: 8];
					last = 1'b0;
				end
			end
			OP_DONE: begin
				kind_c = KIND_DONE;
				dest_reg = cur_q.dest;
				dest_value = cur_q.data;
				resume_pc = cur_q.pc;
			end
			OP_FATAL: begin
				kind_c = KIND_FATAL;
				bus_address = cur_q.addr;
				resume_pc = cur_q.pc;
				fatal_cause = cur_q.cause;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (out_fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

endmodule

// ===== src/misaligned_load_store_emulator_top.sv =====
// Misaligned load/store emulator top level.
// Save and byte transactions need no further state; a byte ending a load and an unknown-cause trap
// go to the push state, a supported trap via the base state (and the data state for a store, which
// reads a second saved register). The back end pops queued commands and offers one result per cycle
// unless out_stall is high: up to five for a store, four for a load; a full queue holds the input.
// Reset clears all control and load state at once; saved registers are undefined until written.
module misaligned_load_store_emulator_top import mle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [4:0]  reg_index,
	input  logic [31:0] reg_value,
	input  logic [31:0] trap_cause,
	input  logic [31:0] fault_pc,
	input  logic [31:0] instruction,
	input  logic [7:0]  read_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] bus_address,
	output logic [7:0]  write_byte,
	output logic [4:0]  dest_reg,
	output logic [31:0] dest_value,
	output logic [31:0] resume_pc,
	output logic [31:0] fatal_cause,
	output logic        last
);

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	mle_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.reg_index(reg_index),
		.reg_value(reg_value),
		.trap_cause(trap_cause),
		.fault_pc(fault_pc),
		.instruction(instruction),
		.read_byte(read_byte),
		.push(push),
		.q_full(q_full),
		.push_cmd(push_cmd)
	);

	mle_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.pop_cmd(pop_cmd),
		.full(q_full),
		.empty(q_empty)
	);

	mle_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_cmd(pop_cmd),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.bus_address(bus_address),
		.write_byte(write_byte),
		.dest_reg(dest_reg),
		.dest_value(dest_value),
		.resume_pc(resume_pc),
		.fatal_cause(fatal_cause),
		.last(last)
	);

`ifndef ASSERT_OFF
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("Command pushed into a full queue.");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_empty)
		else $error("Command popped from an empty queue.");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_DONE || kind == KIND_FATAL)) |-> last)
		else $error("Done or fatal result not marked as the final transaction.");
`endif

endmodule
